// ===== hdl/assert_macros.svh =====
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PRC_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: condition does not hold");
`define PRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: consequence missing in next cycle");
`else
`define PRC_ASSERT_ALWAYS(lbl, expr)
`define PRC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/prc_pkg.sv =====
package prc_pkg;

    // dividend of both divisions: the 3x pit input clock
    localparam int BASE_W = 22;
    localparam logic [BASE_W-1:0] BASE_CLOCK = 22'd3579545;

    localparam int REQ_W    = 32;
    localparam int RELOAD_W = 17;
    localparam int HZ_W     = 21;
    localparam int TICK_W   = 38;

    localparam logic [REQ_W-1:0] HIGH_LIMIT_HZ = 32'd1193181;
    localparam logic [REQ_W-1:0] LOW_LIMIT_HZ  = 32'd18;

    localparam logic [RELOAD_W-1:0] SLOWEST_RELOAD = 17'h10000;
    localparam logic [RELOAD_W-1:0] FASTEST_RELOAD = 17'd1;

    localparam logic [31:0] TICK_FACTOR = 32'hDBB3A062;

    // floor((q+1)/3) by reciprocal: ceil(2^20/3) for q below 2^19
    localparam int RECIP1_W = 19;
    localparam logic [RECIP1_W-1:0] RECIP1 = 19'd349526;
    localparam int RECIP1_SHIFT = 20;

    // ceil(2^24/3) for q below 2^23
    localparam int RECIP2_W = 23;
    localparam logic [RECIP2_W-1:0] RECIP2 = 23'd5592406;
    localparam int RECIP2_SHIFT = 24;

    typedef struct packed {
        logic [TICK_W-1:0]   tick_interval_ms;
        logic [HZ_W-1:0]     actual_hz;
        logic [RELOAD_W-1:0] reload_count;
    } prc_result_t;

endpackage

// ===== hdl/pit_rate_calculator.sv =====
// path: input registers, divider chain 1, p1, reload2, reload3/tick3, divider chain 2, p2, buffer
// one request per cycle unless stalled; two chains of 22 cells, one quotient bit each
// a two-entry output buffer lets requests keep entering while one result waits
// rst_n is asynchronous, active low: clears all valid bits and the buffer count and pointers
`include "assert_macros.svh"

module pit_rate_calculator
    import prc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] requested_hz
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // [16:0] reload_count, [37:17] actual_hz,
                                   // [75:38] tick_interval_ms, [79:76] zero
);

    localparam int SIDE1_W = 2;
    localparam int SIDE2_W = RELOAD_W + TICK_W;
    localparam int P1_W    = 2 * RECIP1_W;
    localparam int P2_W    = 2 * RECIP2_W;
    localparam int TP_W    = RELOAD_W + 32;

    logic       en;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    // input stage
    logic             v0_reg;
    logic [HZ_W-1:0]  hz0_reg;
    logic             low0_reg;
    logic             high0_reg;

    // first divider
    logic              d1_valid;
    logic [BASE_W-1:0] d1_quo;
    logic [SIDE1_W-1:0] d1_side;

    logic                v1_reg;
    logic [P1_W-1:0]     p1_reg;
    logic [SIDE1_W-1:0]  cls1_reg;
    logic [RECIP1_W-1:0] q1_inc;

    logic                v2_reg;
    logic [RELOAD_W-1:0] reload2_reg;
    logic [RELOAD_W-1:0] reload2_next;

    logic                v3_reg;
    logic [RELOAD_W-1:0] reload3_reg;
    logic [TICK_W-1:0]   tick3_reg;
    logic [TP_W-1:0]     tick_prod;

    // second divider
    logic               d2_valid;
    logic [BASE_W-1:0]  d2_quo;
    logic [SIDE2_W-1:0] d2_side;

    logic                v4_reg;
    logic [P2_W-1:0]     p2_reg;
    logic [SIDE2_W-1:0]  side4_reg;
    logic [RECIP2_W-1:0] q2_inc;

    // output buffer
    prc_result_t buf_reg [0:1];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic        push;
    logic        pop;
    prc_result_t push_data;

    assign en       = (cnt_reg != 2'd2);
    assign s_tready = en;
    assign push     = en && v4_reg;
    assign pop      = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= s_tvalid;
            v1_reg <= d1_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hz0_reg   <= s_tdata[HZ_W-1:0];
            low0_reg  <= (s_tdata <= LOW_LIMIT_HZ);
            high0_reg <= (s_tdata >= HIGH_LIMIT_HZ);
        end
    end

    prc_div_chain #(
        .NW (HZ_W),
        .SW (SIDE1_W)
    ) u_div1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v0_reg),
        .divisor   (hz0_reg),
        .in_side   ({high0_reg, low0_reg}),
        .out_valid (d1_valid),
        .quotient  (d1_quo),
        .out_side  (d1_side)
    );

    // the remainder never exceeds half the base clock, so no round-up there;
    // divide by 3 rounding half up equals floor((q+1)/3)
    assign q1_inc = d1_quo[RECIP1_W-1:0] + RECIP1_W'(1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg   <= P1_W'(q1_inc) * P1_W'(RECIP1);
            cls1_reg <= d1_side;
        end
    end

    always_comb
    begin
        if (cls1_reg[0])
        begin
            reload2_next = SLOWEST_RELOAD;
        end
        else if (cls1_reg[1])
        begin
            reload2_next = FASTEST_RELOAD;
        end
        else
        begin
            reload2_next = p1_reg[RECIP1_SHIFT +: RELOAD_W];
        end
    end

    assign tick_prod = TP_W'(reload2_reg) * TP_W'(TICK_FACTOR);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            reload2_reg <= reload2_next;
            reload3_reg <= reload2_reg;
            tick3_reg   <= tick_prod[10 +: TICK_W];
        end
    end

    prc_div_chain #(
        .NW (RELOAD_W),
        .SW (SIDE2_W)
    ) u_div2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .divisor   (reload3_reg),
        .in_side   ({reload3_reg, tick3_reg}),
        .out_valid (d2_valid),
        .quotient  (d2_quo),
        .out_side  (d2_side)
    );

    assign q2_inc = {1'b0, d2_quo} + RECIP2_W'(1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_reg    <= P2_W'(q2_inc) * P2_W'(RECIP2);
            side4_reg <= d2_side;
        end
    end

    always_comb
    begin
        push_data.reload_count     = side4_reg[TICK_W +: RELOAD_W];
        push_data.tick_interval_ms = side4_reg[TICK_W-1:0];
        push_data.actual_hz        = p2_reg[RECIP2_SHIFT +: HZ_W];
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {4'b0, buf_reg[rd_ptr_reg]};

    `PRC_ASSERT_ALWAYS(a_cnt_range, cnt_reg != 2'd3)
    `PRC_ASSERT_ALWAYS(a_ready_room, s_tready == (cnt_reg != 2'd2))
    `PRC_ASSERT_NEXT(a_fill, push && !pop, cnt_reg == $past(cnt_reg) + 2'd1)
    `PRC_ASSERT_ALWAYS(a_reload_range, !m_tvalid || (|m_tdata[16:0] && m_tdata[16:0] <= 17'h10000))

endmodule

// ===== hdl/prc_div_cell.sv =====
module prc_div_cell
    import prc_pkg::*;
#(
    parameter int NW      = 21,
    parameter int SW      = 2,
    parameter bit BIT_VAL = 1'b0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NW-1:0]     in_rem,
    input  logic [NW-1:0]     in_div,
    input  logic [BASE_W-1:0] in_quo,
    input  logic [SW-1:0]     in_side,
    output logic              out_valid,
    output logic [NW-1:0]     out_rem,
    output logic [NW-1:0]     out_div,
    output logic [BASE_W-1:0] out_quo,
    output logic [SW-1:0]     out_side
);

    logic              valid_reg;
    logic [NW-1:0]     rem_reg;
    logic [NW-1:0]     div_reg;
    logic [BASE_W-1:0] quo_reg;
    logic [SW-1:0]     side_reg;

    logic [NW:0]       trial;
    logic              fits;
    logic [NW:0]       rem_next;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {in_rem, BIT_VAL};
        fits     = (trial >= {1'b0, in_div});
        rem_next = fits ? (trial - {1'b0, in_div}) : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next[NW-1:0];
            div_reg  <= in_div;
            quo_reg  <= {in_quo[BASE_W-2:0], fits};
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_div   = div_reg;
    assign out_quo   = quo_reg;
    assign out_side  = side_reg;

endmodule

// ===== hdl/prc_div_chain.sv =====
module prc_div_chain
    import prc_pkg::*;
#(
    parameter int NW = 21,
    parameter int SW = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NW-1:0]     divisor,
    input  logic [SW-1:0]     in_side,
    output logic              out_valid,
    output logic [BASE_W-1:0] quotient,
    output logic [SW-1:0]     out_side
);

    logic              valid_w [0:BASE_W];
    logic [NW-1:0]     rem_w   [0:BASE_W];
    logic [NW-1:0]     div_w   [0:BASE_W];
    logic [BASE_W-1:0] quo_w   [0:BASE_W];
    logic [SW-1:0]     side_w  [0:BASE_W];

    assign valid_w[0] = in_valid;
    assign rem_w[0]   = '0;
    assign div_w[0]   = divisor;
    assign quo_w[0]   = '0;
    assign side_w[0]  = in_side;

    // one quotient bit per cell, dividend bits taken msb first
    for (genvar k = 0; k < BASE_W; k++)
    begin : g_cell
        prc_div_cell #(
            .NW      (NW),
            .SW      (SW),
            .BIT_VAL (BASE_CLOCK[BASE_W-1-k])
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (valid_w[k]),
            .in_rem    (rem_w[k]),
            .in_div    (div_w[k]),
            .in_quo    (quo_w[k]),
            .in_side   (side_w[k]),
            .out_valid (valid_w[k+1]),
            .out_rem   (rem_w[k+1]),
            .out_div   (div_w[k+1]),
            .out_quo   (quo_w[k+1]),
            .out_side  (side_w[k+1])
        );
    end

    assign out_valid = valid_w[BASE_W];
    assign quotient  = quo_w[BASE_W];
    assign out_side  = side_w[BASE_W];

endmodule
